// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// prop must never hold at a rising clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

// File: hw/rtl/fcpl_pkg.sv
`timescale 1ns / 1ps

package fcpl_pkg;

    localparam int PC_W = 5;

    typedef enum logic [2:0] {
        A_SUMAB, A_COS, A_SIN, A_ED, A_EQ, A_ND, A_NQ
    } t_asel;

    typedef enum logic [2:0] {
        B_INV, B_ALPHA, B_BETA, B_KP, B_KI, B_VD, B_VQ
    } t_bsel;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_LOAD, ACC_LOAD16, ACC_ADD, ACC_SUB
    } t_accop;

    typedef enum logic [2:0] {
        WB_NONE, WB_BETA, WB_D, WB_Q, WB_VD, WB_VQ, WB_VA, WB_VB
    } t_wb;

    typedef enum logic [1:0] {
        PI_NONE, PI_D, PI_Q
    } t_pi;

    typedef enum logic [1:0] {
        JMP_NONE, JMP_NO_IN, JMP_OUT_BUSY
    } t_jmp;

    typedef struct packed {
        t_asel            a_sel;
        t_bsel            b_sel;
        t_accop           acc;
        t_wb              wb;
        t_pi              pi;
        logic             take_in;
        logic             deliver;
        t_jmp             jmp;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    localparam t_ctrl CTRL_NOP = '{
        a_sel:   A_COS,
        b_sel:   B_ALPHA,
        acc:     ACC_NONE,
        wb:      WB_NONE,
        pi:      PI_NONE,
        take_in: 1'b0,
        deliver: 1'b0,
        jmp:     JMP_NONE,
        target:  '0
    };

    typedef struct packed {
        logic        [15:0] kp;
        logic        [23:0] ki;
        logic        [30:0] lim;
        logic signed [15:0] tgt_d;
        logic signed [15:0] tgt_q;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] va;
        logic signed [15:0] vb;
        logic signed [15:0] d;
        logic signed [15:0] q;
    } t_result;

endpackage

// File: hw/rtl/fcpl_in_if.sv
`timescale 1ns / 1ps

interface fcpl_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] phase_a_current;
    logic signed [15:0] phase_b_current;
    logic        [7:0]  angle_index;

    modport source (output valid, phase_a_current, phase_b_current, angle_index,
                    input ready);
    modport sink   (input valid, phase_a_current, phase_b_current, angle_index,
                    output ready);
endinterface

// File: hw/rtl/fcpl_out_if.sv
`timescale 1ns / 1ps

interface fcpl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] volt_alpha;
    logic signed [15:0] volt_beta;
    logic signed [15:0] meas_d;
    logic signed [15:0] meas_q;

    modport source (output valid, volt_alpha, volt_beta, meas_d, meas_q,
                    input ready);
    modport sink   (input valid, volt_alpha, volt_beta, meas_d, meas_q,
                    output ready);
endinterface

// File: hw/rtl/fcpl_cfg_if.sv
`timescale 1ns / 1ps

interface fcpl_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [30:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/foc_current_pi_loop.sv
`timescale 1ns / 1ps
// FOC current loop: Clarke, Park, d/q PI regulators and inverse Park.
// Input channel i_in carries phase A/B currents (Q4.12) and an angle index;
// an index past the table length wraps modulo ANGLE_STEPS.
// Output channel o_out carries volt_alpha, volt_beta, meas_d and meas_q.
// Config channel i_cfg writes kp_gain (0), ki_gain_scaled (1), integ_limit (2),
// d_current_target (3) and q_current_target (4); other indexes are dropped.
// It is always ready; write it only while the loop is idle.
// One item runs through a 20-step microprogram on a single 34x25 multiplier
// with a 60-bit accumulator. An input beat is taken only in the idle step, so
// the next beat waits until the previous item has run through the program.
// The output register holds the last result, so the next input beat is
// accepted while the receiver stalls; the program then waits in its last
// step until that register is free.
// Reset clears the integrators, loads the register defaults and returns the
// sequencer to its idle step. The sine/cosine table is a constant built at
// elaboration, so no clearing pass is needed.

`include "assert_macros.svh"

module foc_current_pi_loop #(
    parameter int unsigned ANGLE_STEPS = 200
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fcpl_in_if.sink       i_in,
    fcpl_out_if.source    o_out,
    fcpl_cfg_if.sink      i_cfg
);
    import fcpl_pkg::*;

    localparam logic [2:0] CFG_KP    = 3'd0;
    localparam logic [2:0] CFG_KI    = 3'd1;
    localparam logic [2:0] CFG_LIMIT = 3'd2;
    localparam logic [2:0] CFG_TGT_D = 3'd3;
    localparam logic [2:0] CFG_TGT_Q = 3'd4;

    localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
    localparam logic [PC_W-1:0] PC_LAST = 5'd19;

    // Microprogram. A product is registered at the end of its issue step, the
    // accumulator takes it the next step, write-back reads the accumulator.
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl c;
        c = CTRL_NOP;
        case (pc)
            5'd0: begin
                c.take_in = 1'b1;
                c.jmp     = JMP_NO_IN;
                c.target  = PC_IDLE;
            end
            5'd1:  begin c.a_sel = A_SUMAB; c.b_sel = B_INV; end
            5'd2:  begin c.acc = ACC_LOAD; c.a_sel = A_COS; c.b_sel = B_ALPHA; end
            5'd3:  begin c.wb = WB_BETA; c.acc = ACC_LOAD; end
            5'd4:  begin c.a_sel = A_SIN; c.b_sel = B_BETA; end
            5'd5:  begin c.acc = ACC_ADD; c.a_sel = A_COS; c.b_sel = B_BETA; end
            5'd6: begin
                c.wb = WB_D; c.acc = ACC_LOAD; c.a_sel = A_SIN; c.b_sel = B_ALPHA;
            end
            5'd7:  begin c.acc = ACC_SUB; c.pi = PI_D; end
            5'd8:  begin c.wb = WB_Q; c.a_sel = A_ED; c.b_sel = B_KP; end
            5'd9: begin
                c.pi = PI_Q; c.acc = ACC_LOAD16; c.a_sel = A_ND; c.b_sel = B_KI;
            end
            5'd10: begin c.acc = ACC_ADD; c.a_sel = A_EQ; c.b_sel = B_KP; end
            5'd11: begin
                c.wb = WB_VD; c.acc = ACC_LOAD16; c.a_sel = A_NQ; c.b_sel = B_KI;
            end
            5'd12: begin c.acc = ACC_ADD; c.a_sel = A_COS; c.b_sel = B_VD; end
            5'd13: begin c.wb = WB_VQ; c.acc = ACC_LOAD; end
            5'd14: begin c.a_sel = A_SIN; c.b_sel = B_VQ; end
            5'd15: begin c.acc = ACC_SUB; c.a_sel = A_SIN; c.b_sel = B_VD; end
            5'd16: begin
                c.wb = WB_VA; c.acc = ACC_LOAD; c.a_sel = A_COS; c.b_sel = B_VQ;
            end
            5'd17: begin c.acc = ACC_ADD; end
            5'd18: begin c.wb = WB_VB; end
            5'd19: begin
                c.deliver = 1'b1;
                c.jmp     = JMP_OUT_BUSY;
                c.target  = PC_LAST;
            end
            default: c = CTRL_NOP;
        endcase
        return c;
    endfunction

    logic [PC_W-1:0] r_pc, n_pc;
    t_ctrl           w_ctrl;
    logic            w_in_acc, w_out_free, w_fire;
    t_cfg            r_cfg;
    t_result         w_res;
    logic            r_out_valid;
    t_result         r_out;

    assign w_ctrl     = ucode(r_pc);
    assign i_in.ready = w_ctrl.take_in;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_fire     = w_ctrl.deliver && w_out_free;

    always_comb begin
        n_pc = (r_pc == PC_LAST) ? PC_IDLE : r_pc + 5'd1;
        case (w_ctrl.jmp)
            JMP_NO_IN:    if (!w_in_acc)   n_pc = w_ctrl.target;
            JMP_OUT_BUSY: if (!w_out_free) n_pc = w_ctrl.target;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pc <= PC_IDLE;
        else
            r_pc <= n_pc;
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp    <= 16'd256;
            r_cfg.ki    <= '0;
            r_cfg.lim   <= 31'h7FFF_FFFF;
            r_cfg.tgt_d <= '0;
            r_cfg.tgt_q <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_KP:    r_cfg.kp    <= i_cfg.data[15:0];
                CFG_KI:    r_cfg.ki    <= i_cfg.data[23:0];
                CFG_LIMIT: r_cfg.lim   <= i_cfg.data;
                CFG_TGT_D: r_cfg.tgt_d <= i_cfg.data[15:0];
                CFG_TGT_Q: r_cfg.tgt_q <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    fcpl_datapath #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_load  (w_in_acc),
        .i_a     (i_in.phase_a_current),
        .i_b     (i_in.phase_b_current),
        .i_angle (i_in.angle_index),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // output register: hold the beat until taken, reload on delivery
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_fire)
            r_out_valid <= 1'b1;
        else if (o_out.ready)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_fire)
            r_out <= w_res;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.volt_alpha = r_out.va;
    assign o_out.volt_beta  = r_out.vb;
    assign o_out.meas_d     = r_out.d;
    assign o_out.meas_q     = r_out.q;

    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, w_in_acc |=> !i_in.ready, "input taken while item in flight")
    `ASSERT_CLK(a_result_from_last_step, i_clk, i_rst_n, $rose(o_out.valid) |-> ($past(r_pc) == PC_LAST), "result raised outside delivery step")
    `ASSERT_NEVER(a_pc_range, i_clk, i_rst_n, r_pc > PC_LAST, "step counter past end of program")

endmodule

// File: hw/rtl/fcpl_datapath.sv
`timescale 1ns / 1ps

module fcpl_datapath #(
    parameter int unsigned ANGLE_STEPS = 200
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcpl_pkg::t_ctrl      i_ctrl,
    input  logic                 i_load,
    input  logic signed [15:0]   i_a,
    input  logic signed [15:0]   i_b,
    input  logic        [7:0]    i_angle,
    input  fcpl_pkg::t_cfg       i_cfg,
    output fcpl_pkg::t_result    o_res
);
    import fcpl_pkg::*;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam int          TBL_N   = 256;

    // Taylor series in Q2.30 for 0 <= x <= pi/4
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2, t, s;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        t = ((t * x2) >> 30) / 6;  s = s - t;
        t = ((t * x2) >> 30) / 20; s = s + t;
        t = ((t * x2) >> 30) / 42; s = s - t;
        t = ((t * x2) >> 30) / 72; s = s + t;
        return s;
    endfunction

    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2, t, c;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        c  = ONE_Q30;
        t = ((t * x2) >> 30) / 2;  c = c - t;
        t = ((t * x2) >> 30) / 12; c = c + t;
        t = ((t * x2) >> 30) / 30; c = c - t;
        t = ((t * x2) >> 30) / 56; c = c + t;
        t = ((t * x2) >> 30) / 90; c = c - t;
        return c;
    endfunction

    function automatic logic [15:0] q30_to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd16384) >> 15;
        return (r > 64'd32767) ? 16'h7FFF : r[15:0];
    endfunction

    // cosine in the high half, sine in the low half, both Q1.15
    function automatic logic [31:0] trig_entry(input logic [63:0] p);
        logic [1:0]  quad;
        logic [63:0] r, x;
        logic [15:0] s, c, cs, sn;
        quad = p[31:30];
        r    = p & (ONE_Q30 - 64'd1);
        if (r <= (ONE_Q30 >> 1)) begin
            x = (r * PI_Q30) >> 31;
            s = q30_to_q15(sin_q30(x));
            c = q30_to_q15(cos_q30(x));
        end else begin
            x = ((ONE_Q30 - r) * PI_Q30) >> 31;
            s = q30_to_q15(cos_q30(x));
            c = q30_to_q15(sin_q30(x));
        end
        case (quad)
            2'd0:    begin cs = c;      sn = s;      end
            2'd1:    begin cs = 16'(-s); sn = c;      end
            2'd2:    begin cs = 16'(-c); sn = 16'(-s); end
            default: begin cs = s;      sn = 16'(-c); end
        endcase
        return {cs, sn};
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [59:0] v);
        if (v > 60'sd32767)
            return 16'sh7FFF;
        else if (v < -60'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // Angle table indexed by the raw 8-bit angle, wrap folded in at build
    logic [31:0] w_trig [TBL_N];

    for (genvar j = 0; j < TBL_N; j++) begin : g_trig
        localparam int unsigned IDX = j % ANGLE_STEPS;
        localparam logic [63:0] P   = (64'(IDX) << 32) / 64'(ANGLE_STEPS);
        localparam logic [31:0] ENT = trig_entry(P);
        assign w_trig[j] = ENT;
    end

    logic signed [15:0] r_a, r_cos, r_sin;
    logic signed [17:0] r_sumab, r_beta;
    logic signed [15:0] r_d, r_q, r_vd, r_vq, r_va, r_vb;
    logic signed [16:0] r_ed, r_eq;
    logic signed [32:0] r_nd, r_nq;
    logic signed [31:0] r_integ_d, r_integ_q;
    logic signed [58:0] r_prod;
    logic signed [59:0] r_acc;

    logic signed [33:0] w_ma;
    logic signed [24:0] w_mb;
    logic signed [59:0] w_prod_ext;
    logic signed [59:0] w_rnd;
    logic signed [15:0] w_sat;

    logic signed [15:0] w_meas, w_tgt;
    logic signed [31:0] w_integ;
    logic signed [16:0] w_e;
    logic signed [32:0] w_n, w_lim, w_clamp;

    always_comb begin
        case (i_ctrl.a_sel)
            A_SUMAB: w_ma = {{16{r_sumab[17]}}, r_sumab};
            A_COS:   w_ma = {{18{r_cos[15]}}, r_cos};
            A_SIN:   w_ma = {{18{r_sin[15]}}, r_sin};
            A_ED:    w_ma = {{17{r_ed[16]}}, r_ed};
            A_EQ:    w_ma = {{17{r_eq[16]}}, r_eq};
            A_ND:    w_ma = {r_nd[32], r_nd};
            A_NQ:    w_ma = {r_nq[32], r_nq};
            default: w_ma = '0;
        endcase
        case (i_ctrl.b_sel)
            B_INV:   w_mb = 25'sd37837;
            B_ALPHA: w_mb = {{9{r_a[15]}}, r_a};
            B_BETA:  w_mb = {{7{r_beta[17]}}, r_beta};
            B_KP:    w_mb = {9'b0, i_cfg.kp};
            B_KI:    w_mb = {1'b0, i_cfg.ki};
            B_VD:    w_mb = {{9{r_vd[15]}}, r_vd};
            B_VQ:    w_mb = {{9{r_vq[15]}}, r_vq};
            default: w_mb = '0;
        endcase
    end

    assign w_prod_ext = {r_prod[58], r_prod};

    // round half up at the binary point the write-back target needs
    always_comb begin
        case (i_ctrl.wb)
            WB_BETA:      w_rnd = (r_acc + 60'sd32768) >>> 16;
            WB_VD, WB_VQ: w_rnd = (r_acc + 60'sd8388608) >>> 24;
            default:      w_rnd = (r_acc + 60'sd16384) >>> 15;
        endcase
    end

    assign w_sat = sat16(w_rnd);

    // shared PI unit: error, integrator sum, clamp
    always_comb begin
        if (i_ctrl.pi == PI_Q) begin
            w_meas  = r_q;
            w_tgt   = i_cfg.tgt_q;
            w_integ = r_integ_q;
        end else begin
            w_meas  = r_d;
            w_tgt   = i_cfg.tgt_d;
            w_integ = r_integ_d;
        end
        w_e   = {w_tgt[15], w_tgt} - {w_meas[15], w_meas};
        w_n   = {w_integ[31], w_integ} + {{16{w_e[16]}}, w_e};
        w_lim = $signed({2'b00, i_cfg.lim});
        if (w_n > w_lim)
            w_clamp = w_lim;
        else if (w_n < -w_lim)
            w_clamp = -w_lim;
        else
            w_clamp = w_n;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a     <= i_a;
            r_sumab <= {i_a[15], i_a[15], i_a} + {i_b[15], i_b, 1'b0};
            r_cos   <= w_trig[i_angle][31:16];
            r_sin   <= w_trig[i_angle][15:0];
        end

        r_prod <= w_ma * w_mb;

        case (i_ctrl.acc)
            ACC_LOAD:   r_acc <= w_prod_ext;
            ACC_LOAD16: r_acc <= w_prod_ext <<< 16;
            ACC_ADD:    r_acc <= r_acc + w_prod_ext;
            ACC_SUB:    r_acc <= r_acc - w_prod_ext;
            default:    r_acc <= r_acc;
        endcase

        case (i_ctrl.wb)
            WB_BETA: r_beta <= w_rnd[17:0];
            WB_D:    r_d    <= w_sat;
            WB_Q:    r_q    <= w_sat;
            WB_VD:   r_vd   <= w_sat;
            WB_VQ:   r_vq   <= w_sat;
            WB_VA:   r_va   <= w_sat;
            WB_VB:   r_vb   <= w_sat;
            default: ;
        endcase

        case (i_ctrl.pi)
            PI_D: begin
                r_ed <= w_e;
                r_nd <= w_n;
            end
            PI_Q: begin
                r_eq <= w_e;
                r_nq <= w_n;
            end
            default: ;
        endcase
    end

    // the clamped sum is what persists; the output path uses the raw sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_d <= '0;
            r_integ_q <= '0;
        end else begin
            if (i_ctrl.pi == PI_D)
                r_integ_d <= w_clamp[31:0];
            if (i_ctrl.pi == PI_Q)
                r_integ_q <= w_clamp[31:0];
        end
    end

    assign o_res = '{va: r_va, vb: r_vb, d: r_d, q: r_q};

endmodule

// File: bench/foc_current_pi_loop_checker.sv
`timescale 1ns / 1ps

package fcpl_test_pkg;

    typedef enum logic [2:0] {
        REG_KP, REG_KI, REG_LIMIT, REG_TARGET_D, REG_TARGET_Q
    } t_reg;

    localparam int REG_COUNT = 5;

endpackage

module foc_current_pi_loop_checker #(
    parameter int unsigned ANGLE_STEPS = 200
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fcpl_in_if    i_in,
    fcpl_out_if   i_out,
    fcpl_cfg_if   i_cfg,
    output int    o_fail_count,
    output int    o_pending
);
    import fcpl_pkg::*;
    import fcpl_test_pkg::*;

    typedef longint unsigned t_u64;

    localparam t_u64   PI_Q30        = 64'd3373259426;
    localparam t_u64   ONE_Q30       = 64'd1 << 30;
    localparam longint INV_SQRT3_Q16 = 37837;
    localparam int     REPORT_LIMIT  = 10;

    typedef struct packed {
        logic signed [31:0] integ;
        logic signed [15:0] volt;
    } t_axis;

    logic signed [15:0] cos_rom [ANGLE_STEPS];
    logic signed [15:0] sin_rom [ANGLE_STEPS];

    t_cfg               regs;
    logic signed [31:0] d_integ;
    logic signed [31:0] q_integ;
    t_result            expected_commands [$];
    int                 mismatches;

    function automatic t_u64 taylor_sin(t_u64 x);
        t_u64 x2, t, s;
        x2 = (x * x) >> 30;
        t  = x;
        s  = x;
        t  = ((t * x2) >> 30) / 6;  s = s - t;
        t  = ((t * x2) >> 30) / 20; s = s + t;
        t  = ((t * x2) >> 30) / 42; s = s - t;
        t  = ((t * x2) >> 30) / 72; s = s + t;
        return s;
    endfunction

    function automatic t_u64 taylor_cos(t_u64 x);
        t_u64 x2, t, c;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        c  = ONE_Q30;
        t  = ((t * x2) >> 30) / 2;  c = c - t;
        t  = ((t * x2) >> 30) / 12; c = c + t;
        t  = ((t * x2) >> 30) / 30; c = c - t;
        t  = ((t * x2) >> 30) / 56; c = c + t;
        t  = ((t * x2) >> 30) / 90; c = c - t;
        return c;
    endfunction

    function automatic int q30_to_q15(t_u64 v);
        t_u64 r;
        r = (v + 64'd16384) >> 15;
        return (r > 64'd32767) ? 32767 : int'(r);
    endfunction

    // round half up, then drop n fraction bits
    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic t_axis regulate(logic signed [15:0] meas, logic signed [15:0] target,
                                       logic signed [31:0] integ);
        longint err, sum, acc, lim;
        t_axis  res;
        err = longint'(target) - longint'(meas);
        sum = longint'(integ) + err;
        acc = longint'(regs.kp) * err * 65536 + longint'(regs.ki) * sum;
        lim = longint'(regs.lim);
        // the voltage sees the sum before the clamp
        res.volt = clip16(round_shift(acc, 24));
        if (sum > lim)
            sum = lim;
        else if (sum < -lim)
            sum = -lim;
        res.integ = 32'(sum);
        return res;
    endfunction

    function automatic t_result predict_command(logic signed [15:0] a, logic signed [15:0] b,
                                                logic [7:0] angle);
        int                 idx;
        longint             c, s, alpha, beta;
        logic signed [15:0] d, q, vd, vq;
        t_axis              ad, aq;
        t_result            res;
        idx   = int'(angle % ANGLE_STEPS);
        c     = cos_rom[idx];
        s     = sin_rom[idx];
        alpha = a;
        beta  = round_shift((alpha + 2 * longint'(b)) * INV_SQRT3_Q16, 16);
        d     = clip16(round_shift(c * alpha + s * beta, 15));
        q     = clip16(round_shift(c * beta - s * alpha, 15));
        ad    = regulate(d, regs.tgt_d, d_integ);
        aq    = regulate(q, regs.tgt_q, q_integ);
        d_integ = ad.integ;
        q_integ = aq.integ;
        vd    = ad.volt;
        vq    = aq.volt;
        res.va = clip16(round_shift(c * vd - s * vq, 15));
        res.vb = clip16(round_shift(s * vd + c * vq, 15));
        res.d  = d;
        res.q  = q;
        return res;
    endfunction

    initial begin : build_trig
        t_u64 p, r, x;
        int   quad, sv, cv;
        for (int i = 0; i < ANGLE_STEPS; i++) begin
            p    = (t_u64'(i) << 32) / ANGLE_STEPS;
            quad = int'((p >> 30) & 64'd3);
            r    = p & (ONE_Q30 - 1);
            // fold to the first octant
            if (r <= (ONE_Q30 >> 1)) begin
                x  = (r * PI_Q30) >> 31;
                sv = q30_to_q15(taylor_sin(x));
                cv = q30_to_q15(taylor_cos(x));
            end else begin
                x  = ((ONE_Q30 - r) * PI_Q30) >> 31;
                sv = q30_to_q15(taylor_cos(x));
                cv = q30_to_q15(taylor_sin(x));
            end
            case (quad)
                0: begin
                    cos_rom[i] = 16'(cv);
                    sin_rom[i] = 16'(sv);
                end
                1: begin
                    cos_rom[i] = 16'(-sv);
                    sin_rom[i] = 16'(cv);
                end
                2: begin
                    cos_rom[i] = 16'(-cv);
                    sin_rom[i] = 16'(-sv);
                end
                default: begin
                    cos_rom[i] = 16'(sv);
                    sin_rom[i] = 16'(-cv);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin : watch
        t_result want, got;
        if (!i_rst_n) begin
            regs.kp    = 16'd256;
            regs.ki    = '0;
            regs.lim   = 31'h7FFFFFFF;
            regs.tgt_d = '0;
            regs.tgt_q = '0;
            d_integ    = '0;
            q_integ    = '0;
            mismatches = 0;
            expected_commands.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_KP:       regs.kp    = i_cfg.data[15:0];
                    REG_KI:       regs.ki    = i_cfg.data[23:0];
                    REG_LIMIT:    regs.lim   = i_cfg.data[30:0];
                    REG_TARGET_D: regs.tgt_d = i_cfg.data[15:0];
                    REG_TARGET_Q: regs.tgt_q = i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                expected_commands.push_back(predict_command(i_in.phase_a_current,
                    i_in.phase_b_current, i_in.angle_index));
            if (i_out.valid && i_out.ready) begin
                got.va = i_out.volt_alpha;
                got.vb = i_out.volt_beta;
                got.d  = i_out.meas_d;
                got.q  = i_out.meas_q;
                if (expected_commands.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat with nothing pending: va %0d vb %0d d %0d q %0d",
                                 $realtime, got.va, got.vb, got.d, got.q);
                end else begin
                    want = expected_commands.pop_front();
                    if (got.va !== want.va || got.vb !== want.vb ||
                        got.d !== want.d || got.q !== want.q) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: result mismatch: va %0d/%0d vb %0d/%0d d %0d/%0d q %0d/%0d (expected/actual)",
                                     $realtime, want.va, got.va, want.vb, got.vb,
                                     want.d, got.d, want.q, got.q);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_commands.size();
    end

endmodule

// File: bench/foc_current_pi_loop_test.sv
`timescale 1ns / 1ps

module foc_current_pi_loop_test;
    import fcpl_test_pkg::*;

    localparam int unsigned ANGLE_STEPS      = 200;
    localparam int          RESET_CYCLES     = 9;
    localparam int          MAX_GAP          = 11;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          IDLE_LIMIT       = 2000;
    localparam int          DRAIN_CYCLES     = 40;
    localparam int          RANDOM_PHASES    = 10;
    localparam int          PHASE_ITEMS      = 128;

    logic i_clk         = 1'b0;
    logic i_rst_n       = 1'b0;
    logic calm          = 1'b0;
    logic long_hold_req = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles   = 0;

    fcpl_in_if  in_ch ();
    fcpl_out_if out_ch ();
    fcpl_cfg_if cfg_ch ();

    always #4 i_clk = ~i_clk;

    foc_current_pi_loop #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    foc_current_pi_loop_checker #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) cmd_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_item(input logic [15:0] a, input logic [15:0] b, input logic [7:0] angle);
        int gap;
        gap = calm ? 0 : int'($urandom_range(MAX_GAP, 0));
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.phase_a_current <= a;
        in_ch.phase_b_current <= b;
        in_ch.angle_index     <= angle;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // drop valid and hold until every command beat is back
    task automatic drain_loop();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] kp, input logic [23:0] ki,
                                  input logic [30:0] lim, input logic [15:0] tgt_d,
                                  input logic [15:0] tgt_q);
        logic [2:0]  idx [REG_COUNT + 1];
        logic [30:0] val [REG_COUNT + 1];
        logic [30:0] noise;
        noise  = 31'($urandom);
        idx[0] = REG_KP;       val[0] = {noise[30:16], kp};
        idx[1] = REG_KI;       val[1] = {noise[30:24], ki};
        idx[2] = REG_LIMIT;    val[2] = lim;
        idx[3] = REG_TARGET_D; val[3] = {noise[30:16], tgt_d};
        idx[4] = REG_TARGET_Q; val[4] = {~noise[30:16], tgt_q};
        // a write past the register map must change nothing
        idx[5] = 3'($urandom_range(7, REG_COUNT));
        val[5] = 31'($urandom);
        drain_loop();
        for (int k = 0; k < REG_COUNT + 1; k++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= val[k];
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : receiver
        int gap;
        int hold_left;
        logic hold_taken;
        out_ch.ready = 1'b0;
        gap          = 0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0)
                    out_ch.ready <= 1'b1;
            end else if (long_hold_req && !hold_taken) begin
                hold_taken   = 1'b1;
                hold_left    = LONG_HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (!out_ch.ready) begin
                if (gap > 0)
                    gap--;
                else
                    out_ch.ready <= 1'b1;
            end else if (out_ch.valid) begin
                gap = calm ? 0 : int'($urandom_range(MAX_GAP, 0));
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    gap--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [15:0] kp, tq, td;
        logic [23:0] ki;
        logic [30:0] lim;
        logic [7:0]  angle;
        int          amp, step, pick, va, vb;
        in_ch.valid           = 1'b0;
        in_ch.phase_a_current = '0;
        in_ch.phase_b_current = '0;
        in_ch.angle_index     = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, current extremes, angles at quadrant edges and past the table
        send_item(16'sd0, 16'sd0, 8'd0);
        send_item(16'sh7FFF, 16'sh7FFF, 8'd0);
        send_item(16'sh8000, 16'sh8000, 8'd50);
        send_item(16'sh7FFF, 16'sh8000, 8'd100);
        send_item(16'sh8000, 16'sh7FFF, 8'd150);
        send_item(16'sd12345, -16'sd6789, 8'd199);
        send_item(16'sd4096, 16'sd0, 8'd200);
        send_item(-16'sd4096, 16'sd2048, 8'd255);

        // full gains with a zero limit: stored sums clear, output keeps the raw sum
        apply_settings(16'hFFFF, 24'hFFFFFF, 31'd0, 16'sh7FFF, 16'sh8000);
        send_item(16'sd0, 16'sd0, 8'd25);
        send_item(16'sh7FFF, 16'sh7FFF, 8'd75);
        send_item(16'sh8000, 16'sh8000, 8'd125);
        send_item(16'sd1000, -16'sd1000, 8'd175);
        send_item(16'sd0, 16'sd0, 8'd225);
        send_item(-16'sd1, 16'sd1, 8'd1);

        // pure integral action at the widest limit: wind the sums up
        apply_settings(16'd0, 24'hFFFFFF, 31'h7FFFFFFF, 16'sh8000, 16'sh7FFF);
        repeat (3) send_item(16'sd0, 16'sd0, 8'd10);
        repeat (3) send_item(16'sh7FFF, 16'sh8000, 8'd60);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(3, 0))
                0:       kp = 16'd0;
                1:       kp = 16'hFFFF;
                2:       kp = 16'($urandom_range(1024, 1));
                default: kp = 16'($urandom);
            endcase
            case ($urandom_range(3, 0))
                0:       ki = 24'd0;
                1:       ki = 24'hFFFFFF;
                2:       ki = 24'($urandom_range(65535, 0));
                default: ki = 24'($urandom);
            endcase
            case ($urandom_range(3, 0))
                0:       lim = 31'd0;
                1:       lim = 31'h7FFFFFFF;
                2:       lim = 31'($urandom_range(1 << 20, 1));
                default: lim = 31'($urandom);
            endcase
            td = ($urandom_range(1, 0) != 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(8192, 0)) - 4096);
            tq = ($urandom_range(1, 0) != 0) ? 16'($urandom)
                                              : 16'(int'($urandom_range(8192, 0)) - 4096);
            apply_settings(kp, ki, lim, td, tq);
            calm <= (ph % 4 == 1);
            if (ph == 2)
                long_hold_req <= 1'b1;
            case ($urandom_range(2, 0))
                0:       amp = 256;
                1:       amp = 4096;
                default: amp = 32767;
            endcase
            step  = int'($urandom_range(7, 1));
            angle = 8'($urandom_range(ANGLE_STEPS - 1, 0));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == PHASE_ITEMS / 2)
                    drain_loop();
                pick = int'($urandom_range(9, 0));
                if (pick < 7) begin
                    // steady rotation with bounded phase currents
                    angle = 8'((int'(angle) + step) % ANGLE_STEPS);
                    va    = int'($urandom_range(2 * amp, 0)) - amp;
                    vb    = int'($urandom_range(2 * amp, 0)) - amp;
                    send_item(16'(va), 16'(vb), angle);
                end else if (pick < 9) begin
                    send_item(16'($urandom), 16'($urandom), 8'($urandom_range(255, 0)));
                end else begin
                    send_item(16'($urandom), 16'($urandom),
                              8'($urandom_range(255, ANGLE_STEPS)));
                end
            end
        end

        drain_loop();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/fcpl_pkg.sv
hw/rtl/fcpl_in_if.sv
hw/rtl/fcpl_out_if.sv
hw/rtl/fcpl_cfg_if.sv
hw/rtl/fcpl_datapath.sv
hw/rtl/foc_current_pi_loop.sv
bench/foc_current_pi_loop_checker.sv
bench/foc_current_pi_loop_test.sv
